// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the RTL module vtdi_ctrl.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent leads to a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/vtdi_pkg.sv =====
// ----------------------------------------------------------------------------
// vtdi_pkg
// Shared types and field widths of the vertex triple dedup indexer.
// ----------------------------------------------------------------------------
package vtdi_pkg;

  // Field widths of the channels
  localparam int unsigned IDX_IN_W = 24;
  localparam int unsigned UIDX_W   = 10;
  localparam int unsigned UCNT_W   = 11;

  // One face corner
  typedef struct packed {
    logic [IDX_IN_W-1:0] vertex_index;
    logic [IDX_IN_W-1:0] normal_index;
    logic [IDX_IN_W-1:0] texcoord_index;
    logic                last_in_mesh;
  } in_item_t;

  // One lookup result
  typedef struct packed {
    logic [UIDX_W-1:0] unique_index;
    logic              is_new;
    logic              overflow;
    logic [UCNT_W-1:0] unique_count;
  } result_t;

  // Lookup sequencer states
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_DECIDE = 3'b100
  } state_e;

endpackage

// ===== rtl/core/vtdi_if.sv =====
// ----------------------------------------------------------------------------
// vtdi_if
// Valid/ready channels for face corners in and lookup results out.
// ----------------------------------------------------------------------------
interface vtdi_in_if;
  logic                            valid;
  logic                            ready;
  logic [vtdi_pkg::IDX_IN_W-1:0]   vertex_index;
  logic [vtdi_pkg::IDX_IN_W-1:0]   normal_index;
  logic [vtdi_pkg::IDX_IN_W-1:0]   texcoord_index;
  logic                            last_in_mesh;

  modport source (output valid, vertex_index, normal_index, texcoord_index, last_in_mesh,
                  input ready);
  modport sink   (input valid, vertex_index, normal_index, texcoord_index, last_in_mesh,
                  output ready);
endinterface

interface vtdi_out_if;
  logic                            valid;
  logic                            ready;
  logic [vtdi_pkg::UIDX_W-1:0]     unique_index;
  logic                            is_new;
  logic                            overflow;
  logic [vtdi_pkg::UCNT_W-1:0]     unique_count;

  modport source (output valid, unique_index, is_new, overflow, unique_count,
                  input ready);
  modport sink   (input valid, unique_index, is_new, overflow, unique_count,
                  output ready);
endinterface

// ===== rtl/core/vtdi_ram.sv =====
// ----------------------------------------------------------------------------
// vtdi_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module vtdi_ram #(
  parameter int unsigned WIDTH = 72,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read, one access each per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/vtdi_ctrl.sv =====
// ----------------------------------------------------------------------------
// vtdi_ctrl
// Lookup sequencer: scans the triple table one entry per cycle, then
// appends, reports a hit or flags overflow and updates the entry count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vtdi_ctrl #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned INDEX_BITS  = 24,
  localparam int unsigned AddrW = $clog2(TABLE_DEPTH),
  localparam int unsigned KeyW  = (INDEX_BITS < vtdi_pkg::IDX_IN_W) ?
                                  INDEX_BITS : vtdi_pkg::IDX_IN_W,
  localparam int unsigned EntW  = 3 * KeyW
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // corner transaction
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  vtdi_pkg::in_item_t  in_item_i,
  // result toward the output register
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output vtdi_pkg::result_t   res_o,
  // table memory
  output logic                mem_we_o,
  output logic [AddrW-1:0]    mem_waddr_o,
  output logic [EntW-1:0]     mem_wdata_o,
  output logic                mem_re_o,
  output logic [AddrW-1:0]    mem_raddr_o,
  input  logic [EntW-1:0]     mem_rdata_i
);

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  vtdi_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [AddrW-1:0] k_q, k_d;
  logic [AddrW-1:0] hit_q, hit_d;
  logic             found_q, found_d;
  logic [EntW-1:0]  key_q, key_d;
  logic             last_q, last_d;

  logic             accept;
  logic             match;
  logic             scan_end;
  logic             full;
  logic [AddrW-1:0] idx;
  logic             is_new;
  logic             ovf;
  logic [CntW-1:0]  cnt_after;
  logic [31:0]      idx_ext;
  logic [31:0]      cnt_ext;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == vtdi_pkg::ST_IDLE);
  assign match      = (mem_rdata_i == key_q);
  assign scan_end   = ((CntW'(k_q) + CntW'(1)) == cnt_q);
  assign full       = (cnt_q == CntW'(TABLE_DEPTH));

  // Trim each index to the stored key width and pack the key
  assign key_d = accept ? {in_item_i.vertex_index[KeyW-1:0],
                           in_item_i.normal_index[KeyW-1:0],
                           in_item_i.texcoord_index[KeyW-1:0]} : key_q;
  assign last_d = accept ? in_item_i.last_in_mesh : last_q;

  // Resolve hit, append or overflow
  always_comb begin
    idx       = hit_q;
    is_new    = 1'b0;
    ovf       = 1'b0;
    cnt_after = cnt_q;
    if (!found_q) begin
      if (!full) begin
        idx       = cnt_q[AddrW-1:0];
        is_new    = 1'b1;
        cnt_after = cnt_q + CntW'(1);
      end else begin
        idx = '0;
        ovf = 1'b1;
      end
    end
  end

  assign idx_ext = 32'(idx);
  assign cnt_ext = 32'(cnt_after);

  assign res_valid_o         = (state_q == vtdi_pkg::ST_DECIDE);
  assign res_o.unique_index  = idx_ext[vtdi_pkg::UIDX_W-1:0];
  assign res_o.is_new        = is_new;
  assign res_o.overflow      = ovf;
  assign res_o.unique_count  = cnt_ext[vtdi_pkg::UCNT_W-1:0];

  // Append the new triple when the result leaves
  assign mem_we_o    = res_valid_o && res_ready_i && is_new;
  assign mem_waddr_o = cnt_q[AddrW-1:0];
  assign mem_wdata_o = key_q;

  // Sequence the scan
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    hit_d       = hit_q;
    found_d     = found_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    case (state_q)
      vtdi_pkg::ST_IDLE: begin
        if (accept) begin
          found_d = 1'b0;
          k_d     = '0;
          if (cnt_q == '0) begin
            state_d = vtdi_pkg::ST_DECIDE;
          end else begin
            mem_re_o = 1'b1;
            state_d  = vtdi_pkg::ST_SCAN;
          end
        end
      end
      vtdi_pkg::ST_SCAN: begin
        if (match) begin
          found_d = 1'b1;
          hit_d   = k_q;
          state_d = vtdi_pkg::ST_DECIDE;
        end else if (scan_end) begin
          state_d = vtdi_pkg::ST_DECIDE;
        end else begin
          k_d         = k_q + AddrW'(1);
          mem_re_o    = 1'b1;
          mem_raddr_o = k_q + AddrW'(1);
        end
      end
      vtdi_pkg::ST_DECIDE: begin
        if (res_ready_i) begin
          cnt_d   = last_q ? '0 : cnt_after;
          state_d = vtdi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = vtdi_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vtdi_pkg::ST_IDLE;
      cnt_q   <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      found_q <= found_d;
    end
  end

  // Item registers
  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    hit_q  <= hit_d;
    key_q  <= key_d;
    last_q <= last_d;
  end

  `ASSERT_CLK(a_cnt_in_range, clk_i, rst_ni, cnt_q <= CntW'(TABLE_DEPTH),
              "entry count beyond table depth")
  `ASSERT_CLK(a_scan_below_cnt, clk_i, rst_ni,
              (state_q != vtdi_pkg::ST_SCAN) || (CntW'(k_q) < cnt_q),
              "scan address beyond filled entries")
  `ASSERT_CLK(a_new_xor_ovf, clk_i, rst_ni, !(res_valid_o && is_new && ovf),
              "result both new and overflow")
  `ASSERT_NEXT(a_accept_leaves_idle, clk_i, rst_ni, accept,
               state_q != vtdi_pkg::ST_IDLE, "accepted corner not processed")

endmodule

// ===== rtl/core/vertex_triple_dedup_indexer_top.sv =====
// The lookup reads the triple table memory one entry per cycle until it finds a
// match or reaches the fill count; the decide state then appends the triple,
// reports the hit or flags overflow. The decide state stretches while the output
// register still holds a result that downstream has not taken. Results wait in
// an output register, so a corner may be accepted while the previous result is
// held. The table needs no clearing pass; the entry count returns to zero after
// a corner marked last in mesh.
// ----------------------------------------------------------------------------
// vertex_triple_dedup_indexer_top
// Assigns unique indices to position/normal/texcoord triples of a mesh.
// ----------------------------------------------------------------------------
module vertex_triple_dedup_indexer_top #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned INDEX_BITS  = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  vtdi_in_if.sink   in_i,
  vtdi_out_if.source out_o
);

  localparam int unsigned AddrW = $clog2(TABLE_DEPTH);
  localparam int unsigned KeyW  = (INDEX_BITS < vtdi_pkg::IDX_IN_W) ?
                                  INDEX_BITS : vtdi_pkg::IDX_IN_W;
  localparam int unsigned EntW  = 3 * KeyW;

  vtdi_pkg::in_item_t item;
  vtdi_pkg::result_t  res;
  vtdi_pkg::result_t  out_q;
  logic               res_valid;
  logic               res_ready;
  logic               out_valid_q;
  logic               mem_we;
  logic [AddrW-1:0]   mem_waddr;
  logic [EntW-1:0]    mem_wdata;
  logic               mem_re;
  logic [AddrW-1:0]   mem_raddr;
  logic [EntW-1:0]    mem_rdata;

  assign item.vertex_index   = in_i.vertex_index;
  assign item.normal_index   = in_i.normal_index;
  assign item.texcoord_index = in_i.texcoord_index;
  assign item.last_in_mesh   = in_i.last_in_mesh;

  vtdi_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .INDEX_BITS  (INDEX_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_item_i   (item),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  vtdi_ram #(
    .WIDTH (EntW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Take a new result when the output register is empty or draining
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.unique_index = out_q.unique_index;
  assign out_o.is_new       = out_q.is_new;
  assign out_o.overflow     = out_q.overflow;
  assign out_o.unique_count = out_q.unique_count;

endmodule
